// ===== rtl/jtl_pkg.sv =====
// ----------------------------------------------------------------------------
// jtl_pkg: shared types and constants of the JSON token lexer
// Token kinds, error codes, character codes, the result record carried
// through the result queue, and the keyword spelling table.
// ----------------------------------------------------------------------------
package jtl_pkg;

    // width of the line and column counters
    localparam int POS_BITS = 16;

    // result queue depth, power of two, at least 2
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    // token kinds
    localparam logic [3:0] KIND_OBJ_OPEN  = 4'd0;
    localparam logic [3:0] KIND_OBJ_CLOSE = 4'd1;
    localparam logic [3:0] KIND_ARR_OPEN  = 4'd2;
    localparam logic [3:0] KIND_ARR_CLOSE = 4'd3;
    localparam logic [3:0] KIND_COLON     = 4'd4;
    localparam logic [3:0] KIND_COMMA     = 4'd5;
    localparam logic [3:0] KIND_TRUE      = 4'd6;
    localparam logic [3:0] KIND_FALSE     = 4'd7;
    localparam logic [3:0] KIND_NULL      = 4'd8;
    localparam logic [3:0] KIND_END       = 4'd9;
    localparam logic [3:0] KIND_STR_START = 4'd10;
    localparam logic [3:0] KIND_STR_CHAR  = 4'd11;
    localparam logic [3:0] KIND_STR_END   = 4'd12;
    localparam logic [3:0] KIND_NUM_CHAR  = 4'd13;
    localparam logic [3:0] KIND_NUM_END   = 4'd14;
    localparam logic [3:0] KIND_ERROR     = 4'd15;

    // error codes
    localparam logic [2:0] ERR_NONE        = 3'd0;
    localparam logic [2:0] ERR_BAD_BYTE    = 3'd1;
    localparam logic [2:0] ERR_UNTERM_STR  = 3'd2;
    localparam logic [2:0] ERR_BAD_NUMBER  = 3'd3;
    localparam logic [2:0] ERR_BAD_LITERAL = 3'd4;

    // keyword selectors
    localparam logic [1:0] LIT_TRUE  = 2'd0;
    localparam logic [1:0] LIT_FALSE = 2'd1;
    localparam logic [1:0] LIT_NULL  = 2'd2;
    localparam logic [1:0] LIT_NONE  = 2'd3;

    // character codes
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_UPPER_E = 8'h45;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_LOWER_E = 8'h65;
    localparam logic [7:0] CH_LOWER_F = 8'h66;
    localparam logic [7:0] CH_LOWER_N = 8'h6E;
    localparam logic [7:0] CH_LOWER_T = 8'h74;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    // token payload without position
    typedef struct packed {
        logic [3:0] kind;
        logic [7:0] ch;
        logic       esc;
        logic [2:0] code;
    } res_t;

    // one full result record
    typedef struct packed {
        res_t                res;
        logic [POS_BITS-1:0] line;
        logic [POS_BITS-1:0] col;
        logic                last;
    } entry_t;

    // results pushed by the front for one byte
    typedef struct packed {
        logic [1:0] cnt;
        entry_t     a;
        entry_t     b;
    } push_t;

    // queue head as seen by the back end
    typedef struct packed {
        logic   valid;
        entry_t head;
    } q_head_t;

    localparam res_t RES_ZERO = '{kind: KIND_OBJ_OPEN, ch: 8'h00, esc: 1'b0,
                                  code: ERR_NONE};

    // keyword length
    function automatic logic [2:0] lit_len(input logic [1:0] k);
        logic [2:0] n;
        unique case (k)
            LIT_TRUE:  n = 3'd4;
            LIT_FALSE: n = 3'd5;
            LIT_NULL:  n = 3'd4;
            default:   n = 3'd0;
        endcase
        return n;
    endfunction

    // keyword spelling table
    function automatic logic [7:0] lit_char(input logic [1:0] k, input logic [2:0] i);
        logic [7:0] c;
        c = CH_NUL;
        unique case (k)
            LIT_TRUE: begin
                unique case (i)
                    3'd0:    c = 8'h74;
                    3'd1:    c = 8'h72;
                    3'd2:    c = 8'h75;
                    3'd3:    c = 8'h65;
                    default: c = CH_NUL;
                endcase
            end
            LIT_FALSE: begin
                unique case (i)
                    3'd0:    c = 8'h66;
                    3'd1:    c = 8'h61;
                    3'd2:    c = 8'h6C;
                    3'd3:    c = 8'h73;
                    3'd4:    c = 8'h65;
                    default: c = CH_NUL;
                endcase
            end
            LIT_NULL: begin
                unique case (i)
                    3'd0:    c = 8'h6E;
                    3'd1:    c = 8'h75;
                    3'd2:    c = 8'h6C;
                    3'd3:    c = 8'h6C;
                    default: c = CH_NUL;
                endcase
            end
            default: c = CH_NUL;
        endcase
        return c;
    endfunction

endpackage

// ===== rtl/json_token_lexer.sv =====
// ----------------------------------------------------------------------------
// json_token_lexer: streaming JSON tokenizer
// Turns JSON text, one byte per transaction, into token transactions.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel carries one text byte per transaction; a zero byte closes the
//   document and returns the line and column counters to zero.
//   m_ channel carries one token per transaction. A byte yields zero, one or
//   two tokens; m_last_of_run marks the final token of a byte. Two tokens
//   come only when a number ends on a byte that is itself a token.
// Timing:
//   a token passes through the result queue and the output register to m_.
//   One byte per cycle is taken while tokens drain at one per cycle; the
//   single-token output port bounds the rate when bytes yield two tokens.
//   s_ready is high while the four-entry result queue has room for two.
// Reset:
//   aresetn clears lexer state, position counters, the queue and m_valid.
// Stall:
//   while m_ready is low the queue fills; s_ready drops once fewer than two
//   entries are free, so no token is lost.
// ----------------------------------------------------------------------------
module json_token_lexer (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [7:0]                    s_text_byte,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [3:0]                    m_token_kind,
    output logic [7:0]                    m_char_value,
    output logic                          m_escaped,
    output logic [2:0]                    m_error_code,
    output logic [jtl_pkg::POS_BITS-1:0]  m_line_number,
    output logic [jtl_pkg::POS_BITS-1:0]  m_column_number,
    output logic                          m_last_of_run
);

    logic             accept;
    logic             room;
    logic             pop;
    jtl_pkg::push_t   push;
    jtl_pkg::q_head_t head;
    jtl_pkg::entry_t  m_entry;

    assign s_ready = room;
    assign accept  = s_valid && room;

    // byte classification and lexer state
    jtl_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .text_byte (s_text_byte),
        .push      (push)
    );

    // decoupling queue
    jtl_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .pop     (pop),
        .room    (room),
        .head    (head)
    );

    // output register
    jtl_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .head    (head),
        .pop     (pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_entry (m_entry)
    );

    assign m_token_kind    = m_entry.res.kind;
    assign m_char_value    = m_entry.res.ch;
    assign m_escaped       = m_entry.res.esc;
    assign m_error_code    = m_entry.res.code;
    assign m_line_number   = m_entry.line;
    assign m_column_number = m_entry.col;
    assign m_last_of_run   = m_entry.last;

endmodule

// ===== rtl/jtl_front.sv =====
// ----------------------------------------------------------------------------
// jtl_front: byte classifier and lexer state
// Classifies each accepted byte against the lexer mode, updates mode,
// number and keyword progress and the position counters, and pushes the
// zero, one or two results of the byte into the result queue.
// ----------------------------------------------------------------------------
module jtl_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  accept,
    input  logic [7:0]            text_byte,
    output jtl_pkg::push_t        push
);

    // lexer modes
    localparam logic [2:0] M_IDLE    = 3'd0;
    localparam logic [2:0] M_STRING  = 3'd1;
    localparam logic [2:0] M_ESCAPE  = 3'd2;
    localparam logic [2:0] M_NUMBER  = 3'd3;
    localparam logic [2:0] M_LITERAL = 3'd4;

    typedef struct packed {
        logic [2:0] mode;
        logic [2:0] phase;
        logic       mant;
        logic [1:0] lkind;
        logic [2:0] lidx;
        logic       err;
    } st_t;

    typedef struct packed {
        st_t            s;
        logic           emit;
        jtl_pkg::res_t  r;
    } step_t;

    localparam st_t ST_RESET = '{mode: M_IDLE, phase: 3'd0, mant: 1'b0,
                                 lkind: jtl_pkg::LIT_TRUE, lidx: 3'd0, err: 1'b0};

    st_t                           st_reg, st_next;
    logic [jtl_pkg::POS_BITS-1:0]  line_reg, line_next, line_upd;
    logic [jtl_pkg::POS_BITS-1:0]  col_reg, col_next, col_upd;
    logic [1:0]                    n_res;
    jtl_pkg::res_t                 r0, r1;

    // result with a kind only
    function automatic jtl_pkg::res_t mk(input logic [3:0] kind);
        jtl_pkg::res_t r;
        r = jtl_pkg::RES_ZERO;
        r.kind = kind;
        return r;
    endfunction

    function automatic jtl_pkg::res_t mk_char(input logic [3:0] kind,
                                              input logic [7:0] c, input logic esc);
        jtl_pkg::res_t r;
        r = jtl_pkg::RES_ZERO;
        r.kind = kind;
        r.ch   = c;
        r.esc  = esc;
        return r;
    endfunction

    function automatic jtl_pkg::res_t mk_err(input logic [2:0] code);
        jtl_pkg::res_t r;
        r = jtl_pkg::RES_ZERO;
        r.kind = jtl_pkg::KIND_ERROR;
        r.code = code;
        return r;
    endfunction

    // error: back to idle, latch unless the byte ends the document
    function automatic st_t raise(input st_t s, input logic [2:0] code,
                                  input logic [7:0] c);
        st_t o;
        o = s;
        o.mode = M_IDLE;
        o.err  = (c != jtl_pkg::CH_NUL);
        o.phase = (c != jtl_pkg::CH_NUL) ? code : 3'd0;
        return o;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= jtl_pkg::CH_0) && (c <= jtl_pkg::CH_9);
    endfunction

    // byte seen between tokens
    function automatic step_t idle_step(input st_t s, input logic [7:0] c);
        step_t o;
        o.s    = s;
        o.emit = 1'b1;
        o.r    = jtl_pkg::RES_ZERO;
        unique case (c) inside
            jtl_pkg::CH_LBRACE: o.r = mk(jtl_pkg::KIND_OBJ_OPEN);
            jtl_pkg::CH_RBRACE: o.r = mk(jtl_pkg::KIND_OBJ_CLOSE);
            jtl_pkg::CH_LBRACK: o.r = mk(jtl_pkg::KIND_ARR_OPEN);
            jtl_pkg::CH_RBRACK: o.r = mk(jtl_pkg::KIND_ARR_CLOSE);
            jtl_pkg::CH_COLON:  o.r = mk(jtl_pkg::KIND_COLON);
            jtl_pkg::CH_COMMA:  o.r = mk(jtl_pkg::KIND_COMMA);
            jtl_pkg::CH_NUL:    o.r = mk(jtl_pkg::KIND_END);
            jtl_pkg::CH_SPACE, jtl_pkg::CH_TAB, jtl_pkg::CH_LF, jtl_pkg::CH_CR: begin
                o.emit = 1'b0;
            end
            jtl_pkg::CH_QUOTE: begin
                o.r = mk(jtl_pkg::KIND_STR_START);
                o.s.mode = M_STRING;
            end
            jtl_pkg::CH_LOWER_T, jtl_pkg::CH_LOWER_F, jtl_pkg::CH_LOWER_N: begin
                o.emit = 1'b0;
                o.s.lkind = (c == jtl_pkg::CH_LOWER_T) ? jtl_pkg::LIT_TRUE :
                            (c == jtl_pkg::CH_LOWER_F) ? jtl_pkg::LIT_FALSE :
                                                         jtl_pkg::LIT_NULL;
                o.s.lidx = 3'd1;
                o.s.mode = M_LITERAL;
            end
            jtl_pkg::CH_MINUS, [jtl_pkg::CH_0:jtl_pkg::CH_9]: begin
                o.r = mk_char(jtl_pkg::KIND_NUM_CHAR, c, 1'b0);
                o.s.mode  = M_NUMBER;
                o.s.phase = (c == jtl_pkg::CH_MINUS) ? 3'd0 : 3'd1;
                o.s.mant  = (c != jtl_pkg::CH_MINUS);
            end
            default: begin
                o.r = mk_err(jtl_pkg::ERR_BAD_BYTE);
                o.s = raise(s, jtl_pkg::ERR_BAD_BYTE, c);
            end
        endcase
        return o;
    endfunction

    // position after counting this byte, saturating
    always_comb begin
        if (text_byte == jtl_pkg::CH_LF || text_byte == jtl_pkg::CH_CR) begin
            line_upd = (&line_reg) ? line_reg : line_reg + 1'b1;
            col_upd  = '0;
        end else begin
            line_upd = line_reg;
            col_upd  = (&col_reg) ? col_reg : col_reg + 1'b1;
        end
    end

    // lexer step
    always_comb begin
        logic       go;
        logic       bad0;
        logic       mset;
        logic [2:0] pn;
        logic [2:0] llen;
        logic [2:0] lidx1;
        st_t        tmp;
        step_t      idl;

        st_next = st_reg;
        n_res   = 2'd0;
        r0      = jtl_pkg::RES_ZERO;
        r1      = jtl_pkg::RES_ZERO;
        go      = 1'b0;
        bad0    = 1'b0;
        mset    = 1'b0;
        pn      = st_reg.phase;
        llen    = jtl_pkg::lit_len(st_reg.lkind);
        lidx1   = st_reg.lidx + 3'd1;
        tmp     = st_reg;
        idl     = '0;

        if (st_reg.err) begin
            n_res = 2'd1;
            if (text_byte == jtl_pkg::CH_NUL) begin
                r0 = mk(jtl_pkg::KIND_END);
                st_next.err   = 1'b0;
                st_next.phase = 3'd0;
                st_next.mode  = M_IDLE;
            end else begin
                r0 = mk_err(st_reg.phase);
            end
        end else begin
            unique case (st_reg.mode)
                M_STRING: begin
                    if (text_byte == jtl_pkg::CH_NUL) begin
                        r0 = mk_err(jtl_pkg::ERR_UNTERM_STR);
                        n_res = 2'd1;
                        st_next = raise(st_reg, jtl_pkg::ERR_UNTERM_STR, text_byte);
                    end else if (text_byte == jtl_pkg::CH_QUOTE) begin
                        r0 = mk(jtl_pkg::KIND_STR_END);
                        n_res = 2'd1;
                        st_next.mode = M_IDLE;
                    end else if (text_byte == jtl_pkg::CH_BSLASH) begin
                        st_next.mode = M_ESCAPE;
                    end else begin
                        r0 = mk_char(jtl_pkg::KIND_STR_CHAR, text_byte, 1'b0);
                        n_res = 2'd1;
                    end
                end
                M_ESCAPE: begin
                    n_res = 2'd1;
                    if (text_byte == jtl_pkg::CH_NUL) begin
                        r0 = mk_err(jtl_pkg::ERR_UNTERM_STR);
                        st_next = raise(st_reg, jtl_pkg::ERR_UNTERM_STR, text_byte);
                    end else begin
                        r0 = mk_char(jtl_pkg::KIND_STR_CHAR, text_byte, 1'b1);
                        st_next.mode = M_STRING;
                    end
                end
                M_NUMBER: begin
                    // which characters continue the number in this phase
                    unique case (st_reg.phase)
                        3'd0: begin
                            if (is_digit(text_byte)) begin
                                go = 1'b1; pn = 3'd1; mset = 1'b1;
                            end else if (text_byte == jtl_pkg::CH_DOT) begin
                                go = 1'b1; pn = 3'd2;
                            end else begin
                                bad0 = 1'b1;
                            end
                        end
                        3'd1: begin
                            if (is_digit(text_byte)) begin
                                go = 1'b1;
                            end else if (text_byte == jtl_pkg::CH_DOT) begin
                                go = 1'b1; pn = 3'd2;
                            end else if (text_byte == jtl_pkg::CH_LOWER_E ||
                                         text_byte == jtl_pkg::CH_UPPER_E) begin
                                go = 1'b1; pn = 3'd3;
                            end
                        end
                        3'd2: begin
                            if (is_digit(text_byte)) begin
                                go = 1'b1; mset = 1'b1;
                            end else if (text_byte == jtl_pkg::CH_LOWER_E ||
                                         text_byte == jtl_pkg::CH_UPPER_E) begin
                                go = 1'b1; pn = 3'd3;
                            end
                        end
                        3'd3: begin
                            if (is_digit(text_byte) || text_byte == jtl_pkg::CH_PLUS ||
                                text_byte == jtl_pkg::CH_MINUS) begin
                                go = 1'b1; pn = 3'd4;
                            end
                        end
                        default: begin
                            if (is_digit(text_byte)) begin
                                go = 1'b1; pn = 3'd4;
                            end
                        end
                    endcase

                    if (go) begin
                        r0 = mk_char(jtl_pkg::KIND_NUM_CHAR, text_byte, 1'b0);
                        n_res = 2'd1;
                        st_next.phase = pn;
                        st_next.mant  = st_reg.mant | mset;
                    end else if (bad0) begin
                        r0 = mk_err(jtl_pkg::ERR_BAD_NUMBER);
                        n_res = 2'd1;
                        st_next = raise(st_reg, jtl_pkg::ERR_BAD_NUMBER, text_byte);
                    end else begin
                        // number ends; with a mantissa digit the byte is lexed again from idle, else a number error
                        tmp.phase = 3'd0;
                        tmp.mode  = M_IDLE;
                        if (!st_reg.mant) begin
                            r0 = mk_err(jtl_pkg::ERR_BAD_NUMBER);
                            n_res = 2'd1;
                            st_next = raise(tmp, jtl_pkg::ERR_BAD_NUMBER, text_byte);
                        end else begin
                            tmp.mant = 1'b0;
                            r0 = mk(jtl_pkg::KIND_NUM_END);
                            idl = idle_step(tmp, text_byte);
                            st_next = idl.s;
                            r1 = idl.r;
                            n_res = idl.emit ? 2'd2 : 2'd1;
                        end
                    end
                end
                M_LITERAL: begin
                    if (st_reg.lkind == jtl_pkg::LIT_NONE || st_reg.lidx >= llen ||
                        text_byte == jtl_pkg::CH_NUL ||
                        text_byte != jtl_pkg::lit_char(st_reg.lkind, st_reg.lidx)) begin
                        r0 = mk_err(jtl_pkg::ERR_BAD_LITERAL);
                        n_res = 2'd1;
                        st_next = raise(st_reg, jtl_pkg::ERR_BAD_LITERAL, text_byte);
                        st_next.lidx = 3'd0;
                    end else if (lidx1 >= llen) begin
                        r0 = mk(jtl_pkg::KIND_TRUE + {2'b00, st_reg.lkind});
                        n_res = 2'd1;
                        st_next.lidx = 3'd0;
                        st_next.mode = M_IDLE;
                    end else begin
                        st_next.lidx = lidx1;
                    end
                end
                default: begin
                    tmp.mode = M_IDLE;
                    idl = idle_step(tmp, text_byte);
                    st_next = idl.s;
                    r0 = idl.r;
                    n_res = idl.emit ? 2'd1 : 2'd0;
                end
            endcase
        end
    end

    // counters restart after the end of a document
    always_comb begin
        if (text_byte == jtl_pkg::CH_NUL) begin
            line_next = '0;
            col_next  = '0;
        end else begin
            line_next = line_upd;
            col_next  = col_upd;
        end
    end

    // results toward the queue
    always_comb begin
        push.cnt    = accept ? n_res : 2'd0;
        push.a.res  = r0;
        push.a.line = line_upd;
        push.a.col  = col_upd;
        push.a.last = (n_res == 2'd1);
        push.b.res  = r1;
        push.b.line = line_upd;
        push.b.col  = col_upd;
        push.b.last = 1'b1;
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg   <= ST_RESET;
            line_reg <= '0;
            col_reg  <= '0;
        end else if (accept) begin
            st_reg   <= st_next;
            line_reg <= line_next;
            col_reg  <= col_next;
        end
    end

endmodule

// ===== rtl/jtl_queue.sv =====
// ----------------------------------------------------------------------------
// jtl_queue: result queue between front and back end
// Takes up to two results per cycle and gives one per cycle while the back end
// takes it. Reports room for two more so the front can take a byte without
// looking at the back.
module jtl_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  jtl_pkg::push_t    push,
    input  logic              pop,
    output logic              room,
    output jtl_pkg::q_head_t  head
);

    jtl_pkg::entry_t                 q_mem_reg [jtl_pkg::QUEUE_DEPTH];
    logic [jtl_pkg::QPTR_BITS-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [jtl_pkg::QPTR_BITS-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [jtl_pkg::QCNT_BITS-1:0]   cnt_reg, cnt_next;
    logic [jtl_pkg::QPTR_BITS-1:0]   wr_ptr_b;

    assign wr_ptr_b = wr_ptr_reg + jtl_pkg::QPTR_BITS'(1);

    // pointer and fill level
    always_comb begin
        wr_ptr_next = wr_ptr_reg + jtl_pkg::QPTR_BITS'(push.cnt);
        rd_ptr_next = rd_ptr_reg + jtl_pkg::QPTR_BITS'(pop);
        cnt_next    = cnt_reg + jtl_pkg::QCNT_BITS'(push.cnt) -
                      jtl_pkg::QCNT_BITS'(pop);
    end

    assign room       = (cnt_reg <= jtl_pkg::QCNT_BITS'(jtl_pkg::QUEUE_DEPTH - 2));
    assign head.valid = (cnt_reg != '0);
    assign head.head  = q_mem_reg[rd_ptr_reg];

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (push.cnt != 2'd0) begin
            q_mem_reg[wr_ptr_reg] <= push.a;
        end
        if (push.cnt == 2'd2) begin
            q_mem_reg[wr_ptr_b] <= push.b;
        end
    end

endmodule

// ===== rtl/jtl_back.sv =====
// ----------------------------------------------------------------------------
// jtl_back: result output stage
// Moves the queue head into the output register whenever that register is
// empty or its transaction completes, and drives the result channel.
// ----------------------------------------------------------------------------
module jtl_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  jtl_pkg::q_head_t  head,
    output logic              pop,
    output logic              m_valid,
    input  logic              m_ready,
    output jtl_pkg::entry_t   m_entry
);

    logic            m_valid_reg, m_valid_next;
    jtl_pkg::entry_t out_reg;

    // load when the register is free or being emptied
    assign pop = head.valid && (!m_valid_reg || m_ready);

    always_comb begin
        if (pop) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (pop) begin
            out_reg <= head.head;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_entry = out_reg;

endmodule

// ===== rtl/jtl_checker.sv =====
// ----------------------------------------------------------------------------
// jtl_checker: port-level checks of the JSON token lexer
// Watches the result channel for stalled transactions holding and for
// consistency of the token fields.
module jtl_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic [3:0]                    m_token_kind,
    input  logic [7:0]                    m_char_value,
    input  logic                          m_escaped,
    input  logic [2:0]                    m_error_code,
    input  logic                          m_last_of_run
);

    // stalled transaction holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_token_kind) &&
        $stable(m_char_value) && $stable(m_last_of_run))
        else $error("result changed while stalled");

    // error code only on error tokens
    a_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_token_kind != jtl_pkg::KIND_ERROR |->
        m_error_code == jtl_pkg::ERR_NONE)
        else $error("error code on non-error token");

    // content byte only on character tokens
    a_char: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_token_kind != jtl_pkg::KIND_STR_CHAR &&
        m_token_kind != jtl_pkg::KIND_NUM_CHAR |-> m_char_value == 8'h00)
        else $error("content byte on non-character token");

    // escape flag only on string content
    a_esc: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_escaped |-> m_token_kind == jtl_pkg::KIND_STR_CHAR)
        else $error("escape flag outside string content");

    // the first of two tokens from one byte is always a number end
    a_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_last_of_run |-> m_token_kind == jtl_pkg::KIND_NUM_END)
        else $error("unexpected token before end of run");

endmodule

bind json_token_lexer jtl_checker u_jtl_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_token_kind  (m_token_kind),
    .m_char_value  (m_char_value),
    .m_escaped     (m_escaped),
    .m_error_code  (m_error_code),
    .m_last_of_run (m_last_of_run)
);
